// ===== hdl/brd_pkg.sv =====
// Shared types and constants for the burst rate detector.
// Beat payload structs, config register indexes and reset values.
// No dependencies.
`default_nettype none

package brd_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_GRACE_START = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRACE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_COUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD = 3'd4;

	localparam logic [31:0] GRACE_START_RST = 32'd0;
	localparam logic [31:0] GRACE_RST = 32'd30000;
	localparam logic [7:0] TRIGGER_COUNT_RST = 8'd12;
	localparam logic [31:0] WINDOW_RST = 32'd6000;
	localparam logic [31:0] HOLD_RST = 32'd10000;

	localparam logic [7:0] MIN_TRIGGER = 8'd2;

	localparam logic CMD_ARRIVAL = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [1:0] KIND_SOUND = 2'd0;
	localparam logic [1:0] KIND_LIGHT = 2'd1;

	typedef struct packed {
		logic cmd;
		logic [1:0] msg_kind;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic flock_active;
		logic window_met;
	} out_item_t;

	typedef struct packed {
		logic [31:0] grace_start_ms;
		logic [31:0] grace_ms;
		logic [7:0] trigger_count;
		logic [31:0] window_ms;
		logic [31:0] hold_ms;
	} cfg_t;

	// read stage contents handed from ring to evaluator
	typedef struct packed {
		logic cmd;
		logic [31:0] now_ms;
		logic hit_valid;
		logic [31:0] stamp;
	} rd_stage_t;

endpackage

`default_nettype wire

// ===== hdl/brd_ring.sv =====
// Timestamp ring: memory, per-slot valid bits, write head and look-back read.
// Depends on brd_pkg.
`default_nettype none

module brd_ring #(
	parameter int unsigned RING_DEPTH = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic accept,
	input wire brd_pkg::in_item_t item,
	input wire logic [7:0] trigger_count,
	input wire logic advance,
	output logic rd_valid,
	output brd_pkg::rd_stage_t rd
);

	localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int unsigned SW = AW + 1;
	localparam logic [7:0] DEPTH8 = 8'(RING_DEPTH);
	localparam logic [SW-1:0] DEPTH_S = SW'(RING_DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);

	logic [31:0] ring_mem_q [RING_DEPTH];
	logic [RING_DEPTH-1:0] slot_valid_q;
	logic [AW-1:0] head_q;
	logic rd_valid_s1;
	logic cmd_s1;
	logic [31:0] now_s1;
	logic hit_valid_s1;
	logic [31:0] stamp_s1;

	logic [7:0] cnt;
	logic [SW-1:0] back_sum;
	logic [SW-1:0] back_wrap;
	logic [AW-1:0] slot;
	logic do_write;
	logic do_read;

	always_comb begin
		if (trigger_count < brd_pkg::MIN_TRIGGER) begin
			cnt = brd_pkg::MIN_TRIGGER;
		end else if (trigger_count > DEPTH8) begin
			cnt = DEPTH8;
		end else begin
			cnt = trigger_count;
		end
		back_sum = {1'b0, head_q} + DEPTH_S - SW'(cnt);
		back_wrap = (back_sum >= DEPTH_S) ? (back_sum - DEPTH_S) : back_sum;
		slot = back_wrap[AW-1:0];
	end

	assign do_write = accept && (item.cmd == brd_pkg::CMD_ARRIVAL) &&
		((item.msg_kind == brd_pkg::KIND_SOUND) || (item.msg_kind == brd_pkg::KIND_LIGHT));
	assign do_read = accept && (item.cmd == brd_pkg::CMD_QUERY);

	always_ff @(posedge clk) begin
		if (do_write) begin
			ring_mem_q[head_q] <= item.now_ms;
		end
		if (do_read) begin
			stamp_s1 <= ring_mem_q[slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			head_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (do_write) begin
				slot_valid_q[head_q] <= 1'b1;
				head_q <= (head_q == LAST_SLOT) ? '0 : head_q + AW'(1);
			end
			if (accept) begin
				rd_valid_s1 <= 1'b1;
			end else if (advance) begin
				rd_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= item.cmd;
			now_s1 <= item.now_ms;
			hit_valid_s1 <= slot_valid_q[slot];
		end
	end

	assign rd_valid = rd_valid_s1;
	assign rd = '{cmd: cmd_s1, now_ms: now_s1, hit_valid: hit_valid_s1, stamp: stamp_s1};

endmodule

`default_nettype wire

// ===== hdl/brd_eval.sv =====
// Window compare, burst flag with hold, and the result register.
// Depends on brd_pkg.
`default_nettype none

module brd_eval (
	input wire logic clk,
	input wire logic arst_n,
	input wire brd_pkg::cfg_t cfg,
	input wire logic rd_valid,
	input wire brd_pkg::rd_stage_t rd,
	output logic advance,
	output logic out_valid,
	input wire logic out_stall,
	output brd_pkg::out_item_t out_data
);

	logic active_q;
	logic [31:0] last_trigger_q;
	logic out_valid_q;
	brd_pkg::out_item_t out_data_q;

	logic [31:0] grace_age;
	logic [31:0] stamp_age;
	logic [31:0] hold_age;
	logic in_grace;
	logic met;
	logic active_nxt;
	logic set_trigger;
	brd_pkg::out_item_t res;

	assign advance = rd_valid && (!out_valid_q || !out_stall);

	always_comb begin
		grace_age = rd.now_ms - cfg.grace_start_ms;
		stamp_age = rd.now_ms - rd.stamp;
		hold_age = rd.now_ms - last_trigger_q;
		in_grace = (cfg.grace_start_ms != '0) && (grace_age < cfg.grace_ms);
		met = 1'b0;
		set_trigger = 1'b0;
		active_nxt = active_q;
		res.flock_active = active_q;
		res.window_met = 1'b0;
		if (rd.cmd == brd_pkg::CMD_QUERY) begin
			if (in_grace) begin
				res.flock_active = 1'b0;
			end else begin
				met = rd.hit_valid && (stamp_age <= cfg.window_ms);
				if (met) begin
					set_trigger = 1'b1;
					active_nxt = 1'b1;
				end else if (active_q && (hold_age >= cfg.hold_ms)) begin
					active_nxt = 1'b0;
				end
				res.flock_active = active_nxt;
				res.window_met = met;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			last_trigger_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				active_q <= active_nxt;
				if (set_trigger) begin
					last_trigger_q <= rd.now_ms;
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule

`default_nettype wire

// ===== hdl/burst_rate_detector_with_hold.sv =====
// Burst rate detector with hold: top level with config registers.
// Depends on brd_pkg, brd_ring, brd_eval.
//
// Usage:
//   Input beats (in_valid/in_stall, in_data) are arrivals (cmd 0) or
//   queries (cmd 1). Sound and light arrivals store now_ms into the ring;
//   a query looks trigger_count entries back and checks the window.
//   Every input beat yields exactly one output beat (out_valid/out_stall,
//   out_data), in order.
//   An accepted beat passes the ring read stage, then the result register.
//   Throughput: one beat per cycle while out_stall is low; the ring memory
//   takes one write or one read per beat; the flag update is combinational.
//   Stall: a stalled result holds; one more beat is taken into the read
//   stage, after which in_stall rises until the result is taken.
//   Reset: all slots invalid (valid flops clear at once, no sweep), head
//   zero, flag clear, config registers at their reset values.
//   Config writes (cfg_we, cfg_index, cfg_wdata) are registered; unknown
//   indexes are ignored. They must be made only while the block is idle;
//   the block itself does not enforce this.
`default_nettype none

module burst_rate_detector_with_hold #(
	parameter int unsigned RING_DEPTH = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire brd_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output brd_pkg::out_item_t out_data,
	input wire logic cfg_we,
	input wire logic [brd_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [brd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	brd_pkg::cfg_t cfg_q;
	logic accept;
	logic advance;
	logic rd_valid;
	brd_pkg::rd_stage_t rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grace_start_ms <= brd_pkg::GRACE_START_RST;
			cfg_q.grace_ms <= brd_pkg::GRACE_RST;
			cfg_q.trigger_count <= brd_pkg::TRIGGER_COUNT_RST;
			cfg_q.window_ms <= brd_pkg::WINDOW_RST;
			cfg_q.hold_ms <= brd_pkg::HOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				brd_pkg::REG_GRACE_START: cfg_q.grace_start_ms <= cfg_wdata;
				brd_pkg::REG_GRACE: cfg_q.grace_ms <= cfg_wdata;
				brd_pkg::REG_TRIGGER_COUNT: cfg_q.trigger_count <= cfg_wdata[7:0];
				brd_pkg::REG_WINDOW: cfg_q.window_ms <= cfg_wdata;
				brd_pkg::REG_HOLD: cfg_q.hold_ms <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign in_stall = rd_valid && !advance;
	assign accept = in_valid && !in_stall;

	brd_ring #(
		.RING_DEPTH(RING_DEPTH)
	) u_ring (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.item(in_data),
		.trigger_count(cfg_q.trigger_count),
		.advance(advance),
		.rd_valid(rd_valid),
		.rd(rd)
	);

	brd_eval u_eval (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.rd_valid(rd_valid),
		.rd(rd),
		.advance(advance),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

endmodule

`default_nettype wire

// ===== hdl/brd_checker.sv =====
// Port-level checks for the burst rate detector, bound to the top level.
// Depends on brd_pkg.
`default_nettype none

module brd_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire brd_pkg::in_item_t in_data,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire brd_pkg::out_item_t out_data
);

	// a met window always leaves the flag set
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.window_met |-> out_data.flock_active)
		else $error("window_met without flock_active");

	// input backs up only behind a pending, stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with free output");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result beat changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> !$past(out_stall))
		else $error("result beat dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_data))
		else $error("stalled input beat changed");

endmodule

bind burst_rate_detector_with_hold brd_checker u_brd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.in_data(in_data),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data(out_data)
);

`default_nettype wire

// ===== tb/tb_burst_rate_detector_with_hold.sv =====
// Testbench for burst_rate_detector_with_hold: directed and random beats checked
// against an in-bench predictor of the arrival ring and burst flag.
// Depends on brd_pkg and the burst_rate_detector_with_hold RTL.
`timescale 1ns / 100ps

module tb_burst_rate_detector_with_hold;

	localparam int RING = 64;
	localparam int HEAD_W = $clog2(RING);

	localparam logic [1:0] KIND_STATUS = 2'd2;
	localparam logic [1:0] KIND_INVALID = 2'd3;

	localparam logic [brd_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [brd_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam int PHASE_ITEMS = 160;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	brd_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	brd_pkg::out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [brd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [brd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int error_count = 0;
	int result_beats = 0;
	int live_items = 0;
	logic [31:0] t_now = '0;

	// predictor state
	brd_pkg::cfg_t cfg_shadow = '{brd_pkg::GRACE_START_RST, brd_pkg::GRACE_RST,
		brd_pkg::TRIGGER_COUNT_RST, brd_pkg::WINDOW_RST, brd_pkg::HOLD_RST};
	logic [31:0] stamp_ring [RING];
	logic stamp_live [RING];
	logic [HEAD_W-1:0] ring_head = '0;
	logic burst_on = 1'b0;
	logic [31:0] last_hit_ms = '0;
	brd_pkg::out_item_t flag_expect_q[$];

	burst_rate_detector_with_hold #(
		.RING_DEPTH(RING)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < RING; i++) begin
			stamp_ring[i] = '0;
			stamp_live[i] = 1'b0;
		end
	end

	function automatic int eff_trigger();
		int need;
		need = cfg_shadow.trigger_count;
		if (need < brd_pkg::MIN_TRIGGER) need = brd_pkg::MIN_TRIGGER;
		if (need > RING) need = RING;
		return need;
	endfunction

	function automatic brd_pkg::out_item_t burst_predict(input brd_pkg::in_item_t it);
		brd_pkg::out_item_t res;
		logic [HEAD_W-1:0] slot;
		logic [31:0] age;
		logic hit;
		res = '0;
		if (it.cmd == brd_pkg::CMD_ARRIVAL) begin
			if (it.msg_kind == brd_pkg::KIND_SOUND || it.msg_kind == brd_pkg::KIND_LIGHT) begin
				stamp_ring[ring_head] = it.now_ms;
				stamp_live[ring_head] = 1'b1;
				ring_head = ring_head + 1'b1;
			end
			res.flock_active = burst_on;
			return res;
		end
		age = it.now_ms - cfg_shadow.grace_start_ms;
		if (cfg_shadow.grace_start_ms != '0 && age < cfg_shadow.grace_ms)
			return res;
		slot = ring_head - HEAD_W'(eff_trigger());
		age = it.now_ms - stamp_ring[slot];
		hit = stamp_live[slot] && (age <= cfg_shadow.window_ms);
		if (hit) begin
			last_hit_ms = it.now_ms;
			burst_on = 1'b1;
		end else if (burst_on) begin
			age = it.now_ms - last_hit_ms;
			if (age >= cfg_shadow.hold_ms) burst_on = 1'b0;
		end
		res.flock_active = burst_on;
		res.window_met = hit;
		return res;
	endfunction

	task automatic log_error(input string msg);
		error_count++;
		if (error_count <= 100) $display("%0t ERROR %s", $time, msg);
	endtask

	// result checker
	always @(posedge clk) begin
		brd_pkg::out_item_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (flag_expect_q.size() == 0) begin
				log_error($sformatf("result beat %0d with nothing pending", result_beats));
			end else begin
				exp_res = flag_expect_q.pop_front();
				if (out_data.flock_active !== exp_res.flock_active ||
						out_data.window_met !== exp_res.window_met)
					log_error($sformatf("result beat %0d: flock_active %b exp %b, window_met %b exp %b",
						result_beats, out_data.flock_active, exp_res.flock_active,
						out_data.window_met, exp_res.window_met));
			end
			result_beats++;
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
	end

	task automatic send_item(input brd_pkg::in_item_t it);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		flag_expect_q.push_back(burst_predict(it));
		if (it.cmd == brd_pkg::CMD_QUERY || it.msg_kind == brd_pkg::KIND_SOUND ||
				it.msg_kind == brd_pkg::KIND_LIGHT)
			live_items++;
	endtask

	task automatic send_fields(input logic cmd, input logic [1:0] kind, input logic [31:0] now);
		brd_pkg::in_item_t it;
		it.cmd = cmd;
		it.msg_kind = kind;
		it.now_ms = now;
		send_item(it);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (flag_expect_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [brd_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			brd_pkg::REG_GRACE_START: cfg_shadow.grace_start_ms = val;
			brd_pkg::REG_GRACE: cfg_shadow.grace_ms = val;
			brd_pkg::REG_TRIGGER_COUNT: cfg_shadow.trigger_count = val[7:0];
			brd_pkg::REG_WINDOW: cfg_shadow.window_ms = val;
			brd_pkg::REG_HOLD: cfg_shadow.hold_ms = val;
			default: ;
		endcase
	endtask

	function automatic logic [1:0] random_kind(input int junk_pct);
		if ($urandom_range(0, 99) < junk_pct)
			return $urandom_range(0, 1) ? KIND_STATUS : KIND_INVALID;
		return $urandom_range(0, 1) ? brd_pkg::KIND_LIGHT : brd_pkg::KIND_SOUND;
	endfunction

	task automatic test_empty_ring_and_ignored_kinds();
		send_fields(brd_pkg::CMD_QUERY, KIND_STATUS, 32'd0);
		send_fields(brd_pkg::CMD_ARRIVAL, KIND_STATUS, 32'd1);
		send_fields(brd_pkg::CMD_ARRIVAL, KIND_INVALID, 32'd2);
		send_fields(brd_pkg::CMD_QUERY, KIND_INVALID, 32'd3);
		drain_results();
	endtask

	task automatic test_window_edges_zero_hold();
		write_reg(brd_pkg::REG_TRIGGER_COUNT, 32'hABCD_0001);
		write_reg(brd_pkg::REG_WINDOW, 32'd100);
		write_reg(brd_pkg::REG_HOLD, 32'd0);
		send_fields(brd_pkg::CMD_ARRIVAL, brd_pkg::KIND_SOUND, 32'd10);
		send_fields(brd_pkg::CMD_ARRIVAL, brd_pkg::KIND_LIGHT, 32'd20);
		send_fields(brd_pkg::CMD_QUERY, brd_pkg::KIND_SOUND, 32'd110);
		send_fields(brd_pkg::CMD_QUERY, brd_pkg::KIND_LIGHT, 32'd111);
		drain_results();
	endtask

	task automatic test_wrap_and_long_hold();
		write_reg(brd_pkg::REG_HOLD, 32'hFFFF_FFFF);
		write_reg(brd_pkg::REG_TRIGGER_COUNT, 32'd0);
		send_fields(brd_pkg::CMD_ARRIVAL, brd_pkg::KIND_SOUND, 32'hFFFF_FFF0);
		send_fields(brd_pkg::CMD_ARRIVAL, brd_pkg::KIND_LIGHT, 32'hFFFF_FFFF);
		send_fields(brd_pkg::CMD_QUERY, brd_pkg::KIND_SOUND, 32'h0000_0010);
		send_fields(brd_pkg::CMD_QUERY, brd_pkg::KIND_SOUND, 32'h0000_1000);
		drain_results();
		write_reg(brd_pkg::REG_WINDOW, 32'hFFFF_FFFF);
		send_fields(brd_pkg::CMD_QUERY, KIND_INVALID, 32'h8000_0000);
		drain_results();
	endtask

	task automatic test_trigger_clamp();
		write_reg(brd_pkg::REG_TRIGGER_COUNT, 32'd255);
		send_fields(brd_pkg::CMD_QUERY, brd_pkg::KIND_SOUND, 32'h8000_0001);
		drain_results();
		write_reg(brd_pkg::REG_TRIGGER_COUNT, 32'd3);
		send_fields(brd_pkg::CMD_QUERY, brd_pkg::KIND_LIGHT, 32'h8000_0002);
		drain_results();
	endtask

	task automatic test_grace_period();
		write_reg(brd_pkg::REG_GRACE_START, 32'd1000);
		write_reg(brd_pkg::REG_GRACE, 32'd500);
		send_fields(brd_pkg::CMD_QUERY, brd_pkg::KIND_SOUND, 32'd1200);
		send_fields(brd_pkg::CMD_ARRIVAL, brd_pkg::KIND_SOUND, 32'd1300);
		send_fields(brd_pkg::CMD_QUERY, brd_pkg::KIND_SOUND, 32'd1500);
		send_fields(brd_pkg::CMD_QUERY, brd_pkg::KIND_LIGHT, 32'd999);
		drain_results();
		write_reg(brd_pkg::REG_GRACE, 32'hFFFF_FFFF);
		send_fields(brd_pkg::CMD_QUERY, brd_pkg::KIND_SOUND, 32'd1000);
		send_fields(brd_pkg::CMD_QUERY, brd_pkg::KIND_SOUND, 32'd999);
		drain_results();
		write_reg(brd_pkg::REG_GRACE, 32'd0);
		send_fields(brd_pkg::CMD_QUERY, KIND_STATUS, 32'd1000);
		drain_results();
		write_reg(brd_pkg::REG_GRACE_START, brd_pkg::GRACE_START_RST);
		write_reg(brd_pkg::REG_GRACE, brd_pkg::GRACE_RST);
	endtask

	task automatic test_unused_index();
		write_reg(REG_SPARE_LO, 32'd0);
		write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
		send_fields(brd_pkg::CMD_ARRIVAL, brd_pkg::KIND_LIGHT, 32'h0000_2000);
		send_fields(brd_pkg::CMD_QUERY, brd_pkg::KIND_SOUND, 32'h0000_2001);
		drain_results();
	endtask

	// bursts of closely spaced arrivals with queries mixed in, quiet gaps, and noise
	task automatic run_traffic(input int n);
		int goal;
		int pick;
		int len;
		int need;
		longint step_max;
		longint gap_max;
		brd_pkg::in_item_t it;
		goal = live_items + n;
		while (live_items < goal) begin
			pick = $urandom_range(0, 99);
			need = eff_trigger();
			if (pick < 70) begin
				len = $urandom_range(2, (need + 6 > 70) ? 70 : need + 6);
				step_max = longint'(cfg_shadow.window_ms) * 2 / need + 1;
				if (step_max > 20000) step_max = 20000;
				repeat (len) begin
					t_now += $urandom_range(0, int'(step_max));
					it.now_ms = t_now;
					it.cmd = ($urandom_range(0, 99) < 25) ? brd_pkg::CMD_QUERY :
						brd_pkg::CMD_ARRIVAL;
					it.msg_kind = random_kind(10);
					send_item(it);
				end
			end else if (pick < 85) begin
				gap_max = longint'(cfg_shadow.hold_ms) * 2 + 1;
				if (gap_max > 60000) gap_max = 60000;
				t_now += $urandom_range(0, int'(gap_max));
				send_fields(brd_pkg::CMD_QUERY, random_kind(50), t_now);
			end else begin
				it.now_ms = $urandom;
				it.cmd = 1'($urandom_range(0, 1));
				it.msg_kind = 2'($urandom_range(0, 3));
				send_item(it);
			end
		end
	endtask

	task automatic test_random_traffic(input int phase);
		logic [31:0] trig_pick;
		drain_results();
		t_now = $urandom;
		case (phase)
			0: begin
				src_idle_pct = 33;
				sink_stall_pct = 88;
				write_reg(brd_pkg::REG_GRACE_START, 32'd0);
				write_reg(brd_pkg::REG_TRIGGER_COUNT, $urandom_range(0, 16));
				write_reg(brd_pkg::REG_WINDOW, $urandom_range(200, 3000));
				write_reg(brd_pkg::REG_HOLD, $urandom_range(0, 8000));
			end
			1: begin
				src_idle_pct = 88;
				sink_stall_pct = 33;
				write_reg(brd_pkg::REG_TRIGGER_COUNT, $urandom_range(2, 24));
				write_reg(brd_pkg::REG_WINDOW, $urandom_range(500, 5000));
				write_reg(brd_pkg::REG_HOLD, $urandom);
				write_reg(brd_pkg::REG_GRACE_START, t_now + $urandom_range(1, 2000));
				write_reg(brd_pkg::REG_GRACE, $urandom_range(500, 3000));
			end
			default: begin
				src_idle_pct = 0;
				sink_stall_pct = 0;
				t_now = 32'hFFFF_FFFF - $urandom_range(0, 20000);
				case ($urandom_range(0, 5))
					0: trig_pick = 32'd0;
					1: trig_pick = 32'd1;
					2: trig_pick = 32'd64;
					3: trig_pick = 32'd65;
					4: trig_pick = 32'd255;
					default: trig_pick = $urandom_range(2, 12);
				endcase
				write_reg(brd_pkg::REG_TRIGGER_COUNT,
					{24'($urandom_range(0, 32'hFF_FFFF)), trig_pick[7:0]});
				case ($urandom_range(0, 2))
					0: write_reg(brd_pkg::REG_HOLD, 32'd0);
					1: write_reg(brd_pkg::REG_HOLD, 32'hFFFF_FFFF);
					default: write_reg(brd_pkg::REG_HOLD, $urandom_range(0, 20000));
				endcase
				case ($urandom_range(0, 3))
					0: write_reg(brd_pkg::REG_WINDOW, 32'd0);
					1: write_reg(brd_pkg::REG_WINDOW, 32'hFFFF_FFFF);
					default: write_reg(brd_pkg::REG_WINDOW, $urandom_range(100, 4000));
				endcase
				write_reg(brd_pkg::REG_GRACE_START, $urandom);
				write_reg(brd_pkg::REG_GRACE, $urandom_range(0, 1000));
			end
		endcase
		run_traffic(PHASE_ITEMS / 2);
		// hold off until every pending result is out
		drain_results();
		run_traffic(PHASE_ITEMS - PHASE_ITEMS / 2);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		src_idle_pct = 33;
		sink_stall_pct = 88;
		test_empty_ring_and_ignored_kinds();
		test_window_edges_zero_hold();
		test_wrap_and_long_hold();
		test_trigger_clamp();
		test_grace_period();
		test_unused_index();
		test_random_traffic(0);
		test_random_traffic(1);
		test_random_traffic(2);
		drain_results();
		repeat (8) @(negedge clk);
		if (error_count == 0) begin
			$display("tb_burst_rate_detector_with_hold: done, clean");
		end else begin
			$display("tb_burst_rate_detector_with_hold: done, errors");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_burst_rate_detector_with_hold: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/brd_pkg.sv
hdl/brd_ring.sv
hdl/brd_eval.sv
hdl/burst_rate_detector_with_hold.sv
hdl/brd_checker.sv
tb/tb_burst_rate_detector_with_hold.sv
